// ----- design/clrg_pkg.sv -----
// Shared types and constants for the clamped linear ramp generator.
// No dependencies; imported by clrg_muldiv and the top level.
package clrg_pkg;

    // Item kinds carried in the input tuser field
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SET    = 2'd1,
        OP_RAMP   = 2'd2,
        OP_CANCEL = 2'd3
    } clrg_op_t;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INIT_LEVEL = 2'd2;

    // Register reset values, Q16.16
    localparam int RANGE_LOW_RESET  = 0;
    localparam int RANGE_HIGH_RESET = 65536;
    localparam int INIT_LEVEL_RESET = 0;

    // Shared multiply/divide unit job kinds
    typedef enum logic {
        MD_INTERP  = 1'b0,
        MD_SHORTEN = 1'b1
    } clrg_md_kind_t;

    typedef struct packed {
        logic          start;
        clrg_md_kind_t kind;
    } clrg_md_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } clrg_md_stat_t;

endpackage

// ----- design/clrg_muldiv.sv -----
// Shared multiply-then-divide unit: floor(fac_a * fac_b / divisor), one quotient bit a cycle.
// Depends on clrg_pkg (request/status structs, job kinds).
module clrg_muldiv #(
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 24,
    parameter int MW = ((VALUE_BITS + 1) > COUNT_BITS) ? (VALUE_BITS + 1) : COUNT_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  clrg_pkg::clrg_md_req_t    req,
    input  logic [COUNT_BITS-1:0]     fac_a,
    input  logic [VALUE_BITS:0]       fac_b,
    input  logic [MW-1:0]             divisor,
    output logic [MW-1:0]             quotient,
    output clrg_pkg::clrg_md_stat_t   stat
);
    import clrg_pkg::*;

    localparam int BW    = VALUE_BITS + 1;
    localparam int PW    = COUNT_BITS + BW;
    localparam int CNT_W = $clog2(MW + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } md_state_t;

    md_state_t            state_reg;
    clrg_md_kind_t        kind_reg;
    logic [COUNT_BITS-1:0] a_reg;
    logic [BW-1:0]        b_reg;
    logic [MW-1:0]        d_reg;
    logic [PW-1:0]        p_reg;
    logic [MW-1:0]        rem_reg;
    logic [MW-1:0]        low_reg;
    logic [MW-1:0]        q_reg;
    logic [CNT_W-1:0]     cnt_reg;

    logic [BW-1:0]         hi_short;
    logic [COUNT_BITS-1:0] hi_interp;
    logic [MW:0]           trial;
    logic [MW:0]           diff;
    logic                  fits;

    always_comb begin
        hi_short  = p_reg[PW-1:COUNT_BITS];
        hi_interp = p_reg[PW-1:BW];
        trial     = {rem_reg, low_reg[MW-1]};
        diff      = trial - {1'b0, d_reg};
        fits      = ~diff[MW];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (req.start) begin
                        kind_reg  <= req.kind;
                        a_reg     <= fac_a;
                        b_reg     <= fac_b;
                        d_reg     <= divisor;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    p_reg     <= a_reg * b_reg;
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    // upper product bits are the first partial remainder
                    if (kind_reg == MD_SHORTEN) begin
                        if (MW'(hi_short) >= d_reg) begin
                            q_reg     <= MW'({COUNT_BITS{1'b1}});
                            state_reg <= ST_DONE;
                        end else begin
                            rem_reg   <= MW'(hi_short);
                            low_reg   <= MW'(p_reg[COUNT_BITS-1:0]) << (MW - COUNT_BITS);
                            q_reg     <= '0;
                            cnt_reg   <= CNT_W'(COUNT_BITS);
                            state_reg <= ST_DIV;
                        end
                    end else begin
                        rem_reg   <= MW'(hi_interp);
                        low_reg   <= MW'(p_reg[BW-1:0]) << (MW - BW);
                        q_reg     <= '0;
                        cnt_reg   <= CNT_W'(BW);
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg <= fits ? diff[MW-1:0] : trial[MW-1:0];
                    low_reg <= low_reg << 1;
                    q_reg   <= {q_reg[MW-2:0], fits};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1)) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign quotient  = q_reg;
    assign stat.busy = (state_reg != ST_IDLE);
    assign stat.done = (state_reg == ST_DONE);

`ifndef SYNTHESIS
    a_div_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (cnt_reg != '0))
        else $error("divide step with exhausted count");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done |=> !stat.done)
        else $error("done held longer than one cycle");
    a_start_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> (state_reg == ST_IDLE))
        else $error("job started while unit busy");
`endif

endmodule

// ----- design/clamped_linear_ramp_generator_top.sv -----
// Items are taken only in idle. Set, plain cancel and a tick off a ramp or at the goal
// need no divide; a ramp start passes prep and, if clipped with a positive ratio, the
// shortening divide; a tick on a ramp or a mid-ramp cancel waits on the interpolation
// divide, one quotient bit a cycle in clrg_muldiv. A tick result is valid once the block
// is back in idle; a tick stalls while the previous result waits unread. Reset is
// synchronous active low; item registers keep their value. Uses clrg_pkg and clrg_muldiv.
module clamped_linear_ramp_generator_top #(
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input items
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // goal, ramp_length, start_lag, elapsed (from bit 0 up), zero padded
    input  logic [((VALUE_BITS+3*COUNT_BITS+7)/8)*8-1:0] s_axis_tdata,
    // op
    input  logic [1:0]                           s_axis_tuser,
    // result items
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // sample_out, zero padded
    output logic [((VALUE_BITS+7)/8)*8-1:0]      m_axis_tdata,
    // ramp_active
    output logic [0:0]                           m_axis_tuser,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [clrg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [VALUE_BITS-1:0]                cfg_data
);
    import clrg_pkg::*;

    localparam int V        = VALUE_BITS;
    localparam int C        = COUNT_BITS;
    localparam int BW       = V + 1;
    localparam int MW       = (BW > C) ? BW : C;
    localparam int M_DATA_W = ((V + 7) / 8) * 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RAMP_PREP,
        ST_RAMP_SHORT,
        ST_WAIT_SHORT,
        ST_RAMP_APPLY,
        ST_WAIT_TICK,
        ST_WAIT_CANCEL,
        ST_EMIT
    } top_state_t;

    function automatic logic signed [BW-1:0] sx(input logic signed [V-1:0] v);
        return {v[V-1], v};
    endfunction

    function automatic logic [BW-1:0] mag(input logic signed [BW-1:0] v);
        return v[BW-1] ? BW'(-v) : BW'(v);
    endfunction

    top_state_t state_reg;

    // configuration
    logic signed [V-1:0] range_low_reg;
    logic signed [V-1:0] range_high_reg;

    // ramp state
    logic signed [V-1:0]  held_reg;
    logic signed [V-1:0]  origin_reg;
    logic signed [V-1:0]  goal_reg;
    logic signed [BW-1:0] span_reg;
    logic [C-1:0]         total_reg;
    logic [C-1:0]         done_cnt_reg;
    logic                 mode_reg;
    logic                 finished_reg;

    // current item
    clrg_op_t             op_reg;
    logic signed [V-1:0]  item_goal_reg;
    logic [C-1:0]         item_len_reg;
    logic [C-1:0]         item_lag_reg;
    logic [C-1:0]         item_el_reg;

    // ramp start with clipped goal
    logic signed [V-1:0]  bound_reg;
    logic                 clip_reg;
    logic signed [BW-1:0] num_reg;
    logic signed [BW-1:0] den_reg;

    // pending result and output register
    logic [V-1:0]         res_sample_reg;
    logic                 res_active_reg;
    logic                 out_valid_reg;
    logic [V-1:0]         out_sample_reg;
    logic                 out_active_reg;

    // shared unit
    clrg_md_req_t         md_req;
    clrg_md_stat_t        md_stat;
    logic [C-1:0]         md_a;
    logic [BW-1:0]        md_b;
    logic [MW-1:0]        md_d;
    logic [MW-1:0]        md_q;

    // decode helpers
    logic                 tick_at_goal;
    logic                 cancel_interp;
    logic                 short_needed;
    logic [BW-1:0]        span_mag;
    logic [BW-1:0]        num_mag;
    logic [BW-1:0]        den_mag;
    logic [BW-1:0]        origin_x;
    logic [BW-1:0]        q_low;
    logic [BW-1:0]        interp_sum;
    logic [V-1:0]         interp_val;
    logic signed [V-1:0]  clamp_lo;
    logic signed [V-1:0]  clamp_val;
    logic [C-1:0]         step_cnt;
    logic                 step_fin;

    always_comb begin
        tick_at_goal  = finished_reg || (done_cnt_reg >= total_reg);
        cancel_interp = (total_reg != '0) && (item_el_reg < total_reg);
        short_needed  = (num_reg != '0) && (den_reg != '0) && (num_reg[BW-1] == den_reg[BW-1]);
        span_mag      = mag(span_reg);
        num_mag       = mag(num_reg);
        den_mag       = mag(den_reg);

        // origin +/- trunc(n * |span| / total), modulo arithmetic, fits V bits
        origin_x   = BW'(sx(origin_reg));
        q_low      = md_q[BW-1:0];
        interp_sum = span_reg[BW-1] ? (origin_x - q_low) : (origin_x + q_low);
        interp_val = interp_sum[V-1:0];

        // inverted range ends at range_high
        clamp_lo  = (item_goal_reg < range_low_reg) ? range_low_reg : item_goal_reg;
        clamp_val = (clamp_lo > range_high_reg) ? range_high_reg : clamp_lo;

        step_cnt = done_cnt_reg + 1'b1;
        step_fin = (step_cnt >= total_reg);
    end

    // shared unit operands: shortening in RAMP_SHORT, interpolation otherwise
    always_comb begin
        md_req.start = 1'b0;
        md_req.kind  = MD_INTERP;
        md_a         = (op_reg == OP_TICK) ? done_cnt_reg : item_el_reg;
        md_b         = span_mag;
        md_d         = MW'(total_reg);
        if (state_reg == ST_RAMP_SHORT) begin
            md_req.kind  = MD_SHORTEN;
            md_req.start = short_needed;
            md_a         = item_len_reg;
            md_b         = num_mag;
            md_d         = MW'(den_mag);
        end else if (state_reg == ST_DECODE && mode_reg) begin
            md_req.start = ((op_reg == OP_TICK) && !tick_at_goal) ||
                           ((op_reg == OP_CANCEL) && cancel_interp);
        end
    end

    clrg_muldiv #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS),
        .MW         (MW)
    ) u_muldiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (md_req),
        .fac_a    (md_a),
        .fac_b    (md_b),
        .divisor  (md_d),
        .quotient (md_q),
        .stat     (md_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            range_low_reg  <= V'(RANGE_LOW_RESET);
            range_high_reg <= V'(RANGE_HIGH_RESET);
            held_reg       <= V'(INIT_LEVEL_RESET);
            origin_reg     <= '0;
            goal_reg       <= '0;
            span_reg       <= '0;
            total_reg      <= '0;
            done_cnt_reg   <= '0;
            mode_reg       <= 1'b0;
            finished_reg   <= 1'b1;
            out_valid_reg  <= 1'b0;
        end else begin
            // EMIT reloads the output register itself
            if (out_valid_reg && m_axis_tready && state_reg != ST_EMIT) begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (cfg_valid) begin
                        unique case (cfg_index)
                            REG_RANGE_LOW:  range_low_reg  <= cfg_data;
                            REG_RANGE_HIGH: range_high_reg <= cfg_data;
                            REG_INIT_LEVEL: begin
                                // new level is held unclamped and ends any ramp
                                held_reg <= cfg_data;
                                mode_reg <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                    if (s_axis_tvalid) begin
                        op_reg        <= clrg_op_t'(s_axis_tuser);
                        item_goal_reg <= s_axis_tdata[V-1:0];
                        item_len_reg  <= s_axis_tdata[V +: C];
                        item_lag_reg  <= s_axis_tdata[V+C +: C];
                        item_el_reg   <= s_axis_tdata[V+2*C +: C];
                        state_reg     <= ST_DECODE;
                    end
                end

                ST_DECODE: begin
                    unique case (op_reg)
                        OP_TICK: begin
                            if (!mode_reg) begin
                                res_sample_reg <= held_reg;
                                res_active_reg <= 1'b0;
                                state_reg      <= ST_EMIT;
                            end else if (tick_at_goal) begin
                                held_reg       <= goal_reg;
                                finished_reg   <= 1'b1;
                                res_sample_reg <= goal_reg;
                                res_active_reg <= 1'b0;
                                state_reg      <= ST_EMIT;
                            end else begin
                                state_reg <= ST_WAIT_TICK;
                            end
                        end
                        OP_SET: begin
                            held_reg  <= clamp_val;
                            mode_reg  <= 1'b0;
                            state_reg <= ST_IDLE;
                        end
                        OP_RAMP: begin
                            if (item_goal_reg < range_low_reg) begin
                                bound_reg <= range_low_reg;
                                clip_reg  <= 1'b1;
                            end else if (item_goal_reg > range_high_reg) begin
                                bound_reg <= range_high_reg;
                                clip_reg  <= 1'b1;
                            end else begin
                                bound_reg <= item_goal_reg;
                                clip_reg  <= 1'b0;
                            end
                            state_reg <= ST_RAMP_PREP;
                        end
                        OP_CANCEL: begin
                            if (mode_reg && cancel_interp) begin
                                state_reg <= ST_WAIT_CANCEL;
                            end else begin
                                // with no ramp the held value stays
                                if (mode_reg) begin
                                    held_reg <= goal_reg;
                                end
                                mode_reg  <= 1'b0;
                                state_reg <= ST_IDLE;
                            end
                        end
                        default: state_reg <= ST_IDLE;
                    endcase
                end

                ST_RAMP_PREP: begin
                    // length scale = (bound - held) / (goal - held)
                    num_reg       <= sx(bound_reg) - sx(held_reg);
                    den_reg       <= sx(item_goal_reg) - sx(held_reg);
                    item_goal_reg <= clip_reg ? bound_reg : item_goal_reg;
                    state_reg     <= clip_reg ? ST_RAMP_SHORT : ST_RAMP_APPLY;
                end

                ST_RAMP_SHORT: begin
                    // ratio not positive or undefined: jump to the bound
                    if (short_needed) begin
                        state_reg <= ST_WAIT_SHORT;
                    end else begin
                        item_len_reg <= '0;
                        state_reg    <= ST_RAMP_APPLY;
                    end
                end

                ST_WAIT_SHORT: begin
                    if (md_stat.done) begin
                        item_len_reg <= md_q[C-1:0];
                        state_reg    <= ST_RAMP_APPLY;
                    end
                end

                ST_RAMP_APPLY: begin
                    mode_reg <= 1'b1;
                    goal_reg <= item_goal_reg;
                    if (item_len_reg != '0) begin
                        finished_reg <= 1'b0;
                        origin_reg   <= held_reg;
                        span_reg     <= sx(item_goal_reg) - sx(held_reg);
                        total_reg    <= item_len_reg;
                        done_cnt_reg <= item_lag_reg;
                    end else begin
                        finished_reg <= 1'b1;
                        total_reg    <= '0;
                    end
                    state_reg <= ST_IDLE;
                end

                ST_WAIT_TICK: begin
                    if (md_stat.done) begin
                        held_reg       <= interp_val;
                        done_cnt_reg   <= step_cnt;
                        finished_reg   <= step_fin;
                        res_sample_reg <= interp_val;
                        res_active_reg <= !step_fin;
                        state_reg      <= ST_EMIT;
                    end
                end

                ST_WAIT_CANCEL: begin
                    if (md_stat.done) begin
                        held_reg  <= interp_val;
                        mode_reg  <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end

                ST_EMIT: begin
                    if (!out_valid_reg || m_axis_tready) begin
                        out_valid_reg  <= 1'b1;
                        out_sample_reg <= res_sample_reg;
                        out_active_reg <= res_active_reg;
                        state_reg      <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_DATA_W'(out_sample_reg);
    assign m_axis_tuser  = out_active_reg;

`ifndef SYNTHESIS
    a_live_ramp_has_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg && !finished_reg) |-> (total_reg != '0))
        else $error("unfinished ramp with zero length");
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        md_stat.done |-> (state_reg == ST_WAIT_TICK || state_reg == ST_WAIT_CANCEL ||
                          state_reg == ST_WAIT_SHORT))
        else $error("shared unit finished outside a wait state");
    a_ready_unit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !md_stat.busy)
        else $error("item taken while shared unit busy");
`endif

endmodule

// ----- tb/clrg_checker.sv -----
// Checker for the clamped linear ramp generator: watches the item, result and register
// write channels, predicts every tick sample and compares it field by field.
// Depends on clrg_pkg for item kinds, register indexes and reset values.
module clrg_checker #(
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 24
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_axis_tvalid,
    input  logic                                          s_axis_tready,
    input  logic [((VALUE_BITS+3*COUNT_BITS+7)/8)*8-1:0]  s_axis_tdata,
    input  logic [1:0]                                    s_axis_tuser,
    input  logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]               m_axis_tdata,
    input  logic [0:0]                                    m_axis_tuser,
    input  logic                                          cfg_valid,
    input  logic                                          cfg_ready,
    input  logic [clrg_pkg::CFG_INDEX_W-1:0]              cfg_index,
    input  logic [VALUE_BITS-1:0]                         cfg_data,
    output int                                            fail_count,
    output int                                            pending_samples
);
    timeunit 1ns;
    timeprecision 1ps;
    import clrg_pkg::*;

    localparam int VB = VALUE_BITS;
    localparam int CB = COUNT_BITS;
    localparam longint unsigned CNT_MAX = (64'd1 << CB) - 64'd1;

    typedef struct packed {
        logic [VB-1:0] sample;
        logic          active;
    } tick_sample_t;

    tick_sample_t sample_q[$];

    // predicted register and ramp state
    logic signed [VB-1:0] lo_bound, hi_bound;
    logic signed [VB-1:0] held, origin, target;
    logic signed [VB:0]   span;
    logic [CB-1:0]        total, done_cnt;
    logic                 ramping, finished;

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // origin + trunc(n * span / total), n below total
    function automatic longint ramp_point(longint unsigned n);
        longint unsigned q;
        q = (n * magnitude(longint'(span))) / longint'(total);
        return (span < 0) ? longint'(origin) - longint'(q) : longint'(origin) + longint'(q);
    endfunction

    // length scaled by num/den; zero when the ratio is not positive
    function automatic longint unsigned shortened_length(longint unsigned len, longint num,
                                                        longint den);
        longint unsigned n, d, q, r, res;
        if (num == 0 || den == 0 || ((num < 0) != (den < 0)))
            return 0;
        n = magnitude(num);
        d = magnitude(den);
        q = n / d;
        r = n % d;
        if (len != 0 && q > CNT_MAX)
            return CNT_MAX;
        res = len * q + (r * len) / d;
        return (res > CNT_MAX) ? CNT_MAX : res;
    endfunction

    function automatic longint clamp_level(longint v);
        longint t;
        t = (v < longint'(lo_bound)) ? longint'(lo_bound) : v;
        return (t > longint'(hi_bound)) ? longint'(hi_bound) : t;
    endfunction

    task automatic reset_model();
        lo_bound = RANGE_LOW_RESET;
        hi_bound = RANGE_HIGH_RESET;
        held     = INIT_LEVEL_RESET;
        origin   = '0;
        target   = '0;
        span     = '0;
        total    = '0;
        done_cnt = '0;
        ramping  = 1'b0;
        finished = 1'b1;
        sample_q.delete();
    endtask

    task automatic apply_item(clrg_op_t op, logic signed [VB-1:0] goal, logic [CB-1:0] len,
                              logic [CB-1:0] lag, logic [CB-1:0] el);
        longint          s, v, g;
        longint unsigned l;
        case (op)
            OP_TICK: begin
                if (!ramping) begin
                    sample_q.push_back('{sample: held, active: 1'b0});
                end else begin
                    if (finished || done_cnt >= total) begin
                        s = longint'(target);
                        finished = 1'b1;
                    end else begin
                        s = ramp_point(done_cnt);
                        done_cnt = done_cnt + 1'b1;
                        if (done_cnt >= total)
                            finished = 1'b1;
                    end
                    held = s[VB-1:0];
                    sample_q.push_back('{sample: s[VB-1:0], active: !finished});
                end
            end
            OP_SET: begin
                v = clamp_level(longint'(goal));
                held = v[VB-1:0];
                ramping = 1'b0;
            end
            OP_RAMP: begin
                v = longint'(held);
                g = longint'(goal);
                l = len;
                // out-of-range goal: clip it and shorten the length in proportion
                if (g < longint'(lo_bound)) begin
                    l = shortened_length(l, longint'(lo_bound) - v, g - v);
                    g = longint'(lo_bound);
                end else if (g > longint'(hi_bound)) begin
                    l = shortened_length(l, longint'(hi_bound) - v, g - v);
                    g = longint'(hi_bound);
                end
                ramping = 1'b1;
                target  = g[VB-1:0];
                if (l > 0) begin
                    finished = 1'b0;
                    origin   = v[VB-1:0];
                    span     = g - v;
                    total    = l[CB-1:0];
                    done_cnt = lag;
                end else begin
                    finished = 1'b1;
                    total    = '0;
                end
            end
            default: begin
                if (ramping) begin
                    if (total > 0 && el < total) begin
                        s = ramp_point(el);
                        held = s[VB-1:0];
                    end else begin
                        held = target;
                    end
                end
                ramping = 1'b0;
            end
        endcase
    endtask

    always @(posedge aclk) begin
        int           errs;
        tick_sample_t want;
        errs = 0;
        if (!aresetn) begin
            reset_model();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_RANGE_LOW:  lo_bound = cfg_data;
                    REG_RANGE_HIGH: hi_bound = cfg_data;
                    REG_INIT_LEVEL: begin
                        held     = cfg_data;
                        ramping  = 1'b0;
                    end
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                apply_item(clrg_op_t'(s_axis_tuser), s_axis_tdata[VB-1:0],
                           s_axis_tdata[VB+CB-1:VB], s_axis_tdata[VB+2*CB-1:VB+CB],
                           s_axis_tdata[VB+3*CB-1:VB+2*CB]);
            if (m_axis_tvalid && m_axis_tready) begin
                if (sample_q.size() == 0) begin
                    $error("unexpected result item: sample_out %0d ramp_active %0b",
                           $signed(m_axis_tdata[VB-1:0]), m_axis_tuser[0]);
                    errs++;
                end else begin
                    want = sample_q.pop_front();
                    if (want.sample !== m_axis_tdata[VB-1:0]) begin
                        $error("sample_out mismatch: expected %0d, actual %0d",
                               $signed(want.sample), $signed(m_axis_tdata[VB-1:0]));
                        errs++;
                    end
                    if (want.active !== m_axis_tuser[0]) begin
                        $error("ramp_active mismatch: expected %0b, actual %0b",
                               want.active, m_axis_tuser[0]);
                        errs++;
                    end
                end
            end
        end
        fail_count      <= fail_count + errs;
        pending_samples <= sample_q.size();
    end

endmodule

// ----- tb/testbench.sv -----
// Top of the ramp generator testbench: clock, reset, item and register stimulus, the
// result-side ready pattern and the verdict. Checking lives in clrg_checker.
// Depends on clrg_pkg, clrg_checker and clamped_linear_ramp_generator_top.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import clrg_pkg::*;

    localparam int VB       = 32;
    localparam int CB       = 24;
    localparam int TDATA_W  = ((VB + 3*CB + 7) / 8) * 8;
    localparam int MDATA_W  = ((VB + 7) / 8) * 8;

    // The longest item with no result is a mid-ramp cancel, so after the last sample comes
    // we still give the block this long before touching registers.
    localparam int SETTLE_CYCLES = 120;
    // Watchdog limit, several times the worst-case run length.
    localparam int CYCLE_LIMIT   = 400000;
    // Long receiver hold-off used to back the block up into its input.
    localparam int HOLD_CYCLES   = 400;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata  = '0;   // goal, ramp_length, start_lag, elapsed
    logic [1:0]         s_axis_tuser  = '0;   // op
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [MDATA_W-1:0] m_axis_tdata;         // sample_out
    logic [0:0]         m_axis_tuser;         // ramp_active
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [VB-1:0]      cfg_data      = '0;

    int fail_count;
    int pending_samples;

    // stimulus bookkeeping
    int     items_sent = 0;
    int     cycles     = 0;
    logic   calm       = 1'b0;   // no idling on either side while set
    logic   hold_kick  = 1'b0;   // toggle to start one receiver hold-off
    longint cur_lo     = RANGE_LOW_RESET;
    longint cur_hi     = RANGE_HIGH_RESET;

    clamped_linear_ramp_generator_top #(
        .VALUE_BITS (VB),
        .COUNT_BITS (CB)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    clrg_checker #(
        .VALUE_BITS (VB),
        .COUNT_BITS (CB)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_samples (pending_samples)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL clamped_linear_ramp_generator_top");
            $finish;
        end
    end

    // Result side: random ready about 30% low, solid high while calm, and a counted
    // hold-off whenever the stimulus toggles hold_kick.
    always @(posedge aclk) begin
        static logic hold_seen = 1'b0;
        static int   hold_left = 0;
        if (hold_kick != hold_seen) begin
            hold_seen = hold_kick;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 30);
        end
    end

    function automatic logic [CB-1:0] noise24();
        return CB'($urandom);
    endfunction

    // Mostly short ramps so ticks reach the end; now and then huge ones.
    function automatic logic [CB-1:0] pick_length();
        case ($urandom_range(0, 19))
            0:       return '1;
            1, 2:    return noise24();
            3:       return '0;
            default: return CB'($urandom_range(1, 12));
        endcase
    endfunction

    // Lag or elapsed count: usually inside the ramp, sometimes past its end.
    function automatic logic [CB-1:0] pick_offset(logic [CB-1:0] len);
        case ($urandom_range(0, 9))
            0:       return noise24();
            1, 2, 3: return CB'($urandom_range(0, (len < 20 ? int'(len) : 20) + 2));
            default: return '0;
        endcase
    endfunction

    // Goal values: extremes, raw random, inside the range and just around the bounds.
    function automatic logic [VB-1:0] pick_level();
        longint          v;
        longint unsigned width;
        case ($urandom_range(0, 9))
            0:       v = 64'sh7FFF_FFFF;
            1:       v = -64'sh8000_0000;
            2, 3:    v = $signed($urandom);
            4, 5, 6, 7: begin
                if (cur_hi >= cur_lo) begin
                    width = cur_hi - cur_lo + 1;
                    v = cur_lo + longint'({$urandom, $urandom} % width);
                end else begin
                    v = $urandom_range(0, 1) ? cur_lo : cur_hi;
                end
            end
            default: v = ($urandom_range(0, 1) ? cur_lo : cur_hi)
                         + longint'($urandom_range(0, 4096)) - 2048;
        endcase
        return v[VB-1:0];
    endfunction

    // Offer one item and hold it until accepted; idles first at random unless calm.
    task automatic push_item(clrg_op_t op, logic [VB-1:0] goal, logic [CB-1:0] len,
                             logic [CB-1:0] lag, logic [CB-1:0] el);
        while (!calm && $urandom_range(0, 99) < 30) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= TDATA_W'({el, lag, len, goal});
        do @(posedge aclk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic tick();
        push_item(OP_TICK, $urandom, noise24(), noise24(), noise24());
    endtask

    // Stop offering, wait for every expected sample, then let item-only work finish.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_samples != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [VB-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Registers only change with the block idle.
    task automatic apply_setting(longint lo, longint hi, longint init);
        drain();
        write_reg(REG_RANGE_LOW, lo[VB-1:0]);
        write_reg(REG_RANGE_HIGH, hi[VB-1:0]);
        write_reg(REG_INIT_LEVEL, init[VB-1:0]);
        cfg_valid <= 1'b0;
        cur_lo = lo;
        cur_hi = hi;
    endtask

    // Random traffic: mostly ramp starts followed by ticks, with sets, cancels, lone
    // ticks and fully random items mixed in.
    task automatic run_random(int quota);
        int            stop_at;
        int            pick;
        logic [CB-1:0] len;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                len = pick_length();
                push_item(OP_RAMP, pick_level(), len, pick_offset(len), noise24());
                repeat ($urandom_range(0, (len < 12 ? int'(len) : 12) + 3)) begin
                    if ($urandom_range(0, 11) == 0)
                        push_item(OP_CANCEL, $urandom, noise24(), noise24(),
                                  pick_offset(len));
                    tick();
                end
            end else if (pick < 65) begin
                push_item(OP_SET, pick_level(), noise24(), noise24(), noise24());
                tick();
            end else if (pick < 75) begin
                push_item(OP_CANCEL, $urandom, noise24(), noise24(), pick_offset(noise24()));
                tick();
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 4)) tick();
            end else begin
                push_item(clrg_op_t'($urandom_range(0, 3)), $urandom, noise24(), noise24(),
                          noise24());
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed part, reset range [0, 1.0] ----
        tick();                                                  // held reset level
        push_item(OP_CANCEL, '0, '0, '0, '0);                    // cancel with no ramp
        push_item(OP_SET, 32'h7FFF_FFFF, '1, '1, '1);            // clamps to range_high
        tick();
        push_item(OP_SET, 32'h8000_0000, '0, '0, '0);            // clamps to range_low
        tick();
        push_item(OP_RAMP, 32'd65536, 24'd3, 24'd0, '0);         // in-range ramp
        repeat (4) tick();
        // already at the upper bound, goal beyond it: ratio zero, jump to bound
        push_item(OP_RAMP, 32'h7FFF_FFFF, '1, '0, '0);
        tick();
        // goal far below: length shortened, lag past the shortened end
        push_item(OP_RAMP, 32'h8000_0000, '1, '1, '0);
        tick();
        push_item(OP_SET, 32'd32768, '0, '0, '0);
        push_item(OP_RAMP, 32'd196608, 24'd10, 24'd0, '0);       // clipped, shortened
        repeat (3) tick();
        push_item(OP_RAMP, 32'd16384, 24'd0, 24'd5, '0);         // zero length
        tick();
        push_item(OP_RAMP, 32'd65536, 24'd16, 24'd0, '0);
        tick();
        push_item(OP_CANCEL, '0, '0, '0, 24'd5);                 // freeze mid-ramp
        tick();
        push_item(OP_RAMP, 32'd0, 24'd4, 24'd1, '0);
        push_item(OP_CANCEL, '0, '0, '0, '1);                    // cancel past the end
        tick();
        // held level outside the range, goal equal to it: ratio undefined, jump to bound
        apply_setting(RANGE_LOW_RESET, RANGE_HIGH_RESET, 196608);
        push_item(OP_RAMP, 32'd196608, 24'd5, 24'd0, '0);
        tick();

        // ---- random phases over several register settings ----
        // full signed range; the long receiver hold-off happens here
        apply_setting(-64'sh8000_0000, 64'sh7FFF_FFFF, 0);
        run_random(30);
        hold_kick <= ~hold_kick;
        repeat (12) tick();
        run_random(36);

        // moderate range with no idling at all
        apply_setting(-262144, 262144, 100000);
        calm <= 1'b1;
        run_random(66);
        calm <= 1'b0;

        // inverted range: clamp lands on range_high
        apply_setting(65536, -65536, $signed($urandom));
        run_random(66);

        // single-point range
        begin
            longint pt;
            pt = $signed($urandom);
            apply_setting(pt, pt, 0);
        end
        run_random(66);

        // random ordered range, random start level
        begin
            longint a, b;
            a = $signed($urandom);
            b = $signed($urandom);
            apply_setting((a < b) ? a : b, (a < b) ? b : a, $signed($urandom));
        end
        run_random(66);

        // both bounds at the top extreme, start level at the bottom one
        apply_setting(64'sh7FFF_FFFF, 64'sh7FFF_FFFF, -64'sh8000_0000);
        run_random(66);

        drain();
        if (fail_count == 0 && pending_samples == 0) begin
            $display("PASS clamped_linear_ramp_generator_top");
        end else begin
            $display("FAIL clamped_linear_ramp_generator_top");
        end
        $finish;
    end

endmodule
